>>> hw/rtl/emhq_pkg.sv
// Shared types, widths and codes for the event min-heap queue.
// Has no dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package emhq_pkg;

    // Default storage depth of the heap
    localparam int DEPTH_DEFAULT = 1024;

    // Field widths of one event word, the status code and the occupancy count
    localparam int TIME_W   = 32;
    localparam int PROC_W   = 10;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 11;

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // One stored event
    typedef struct packed {
        logic [TIME_W-1:0] ev_time;
        logic [PROC_W-1:0] ev_proc;
        logic [KIND_W-1:0] ev_kind;
    } entry_t;

    // Finished result handed from the sift controller to the output stage
    typedef struct packed {
        logic    valid;
        status_t status;
        entry_t  entry;
    } result_t;

    // True when event x must leave before event y: time first, then process number
    function automatic logic earlier(input entry_t x, input entry_t y);
        logic res;
        if (x.ev_time != y.ev_time)
        begin
            res = (x.ev_time < y.ev_time);
        end
        else
        begin
            res = (x.ev_proc < y.ev_proc);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/event_min_heap_queue.sv
// Event priority queue as a binary min-heap in one synchronous memory.
// An insert climbs the heap and a remove descends it between input accept and out_valid.
// A new word is not taken while one is in flight; the sift walk, one heap level a cycle
// through the memory read ports, sets the pace, and the next word is taken the cycle
// after the result is registered. Output stalls hold the sift controller in its last state.
// Reset: asynchronous, empties the queue at once; heap memory contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module event_min_heap_queue #(
    parameter int HEAP_DEPTH = emhq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            operation,
    input  wire logic [emhq_pkg::TIME_W-1:0]     event_time,
    input  wire logic [emhq_pkg::PROC_W-1:0]     process_index,
    input  wire logic [emhq_pkg::KIND_W-1:0]     event_kind,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [emhq_pkg::TIME_W-1:0]          out_time,
    output logic [emhq_pkg::PROC_W-1:0]          out_process,
    output logic [emhq_pkg::KIND_W-1:0]          out_kind,
    output logic [emhq_pkg::STATUS_W-1:0]        status,
    output logic [emhq_pkg::OCC_W-1:0]           occupancy
);

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);

    logic                              rd_en;
    logic [AW-1:0]                     rd_addr_a;
    logic [AW-1:0]                     rd_addr_b;
    logic                              wr_en;
    logic [AW-1:0]                     wr_addr;
    emhq_pkg::entry_t                  wr_data;
    emhq_pkg::entry_t                  rd_data_a;
    emhq_pkg::entry_t                  rd_data_b;
    emhq_pkg::result_t                 res;
    logic [CW-1:0]                     count;
    logic [CW+emhq_pkg::OCC_W-1:0]     count_ext;

    logic                              out_free;
    logic                              res_take;
    logic                              out_valid_reg, out_valid_next;
    emhq_pkg::entry_t                  word_reg;
    logic [emhq_pkg::STATUS_W-1:0]     status_reg;
    logic [emhq_pkg::OCC_W-1:0]        occ_reg;

    emhq_store #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) u_store (
        .clk       (clk),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    emhq_ctrl #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .event_time    (event_time),
        .process_index (process_index),
        .event_kind    (event_kind),
        .rd_en         (rd_en),
        .rd_addr_a     (rd_addr_a),
        .rd_addr_b     (rd_addr_b),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_data_a     (rd_data_a),
        .rd_data_b     (rd_data_b),
        .res           (res),
        .res_free      (out_free),
        .count         (count)
    );

    // Output register handshake
    assign out_free  = !out_valid_reg || !out_stall;
    assign res_take  = res.valid && out_free;
    assign count_ext = (CW + emhq_pkg::OCC_W)'(count);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the finished word
    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            word_reg   <= res.entry;
            status_reg <= res.status;
            occ_reg    <= count_ext[emhq_pkg::OCC_W-1:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_time    = word_reg.ev_time;
    assign out_process = word_reg.ev_proc;
    assign out_kind    = word_reg.ev_kind;
    assign status      = status_reg;
    assign occupancy   = occ_reg;

endmodule

`default_nettype wire

>>> hw/rtl/emhq_store.sv
// Heap storage: one write port and two read ports with registered read data.
// Depends on emhq_pkg for the entry type and the default depth.
`timescale 1ns / 1ps
`default_nettype none

module emhq_store #(
    parameter int HEAP_DEPTH = emhq_pkg::DEPTH_DEFAULT,
    localparam int AW = $clog2(HEAP_DEPTH)
) (
    input  wire logic            clk,
    input  wire logic            rd_en,
    input  wire logic [AW-1:0]   rd_addr_a,
    input  wire logic [AW-1:0]   rd_addr_b,
    input  wire logic            wr_en,
    input  wire logic [AW-1:0]   wr_addr,
    input  wire emhq_pkg::entry_t wr_data,
    output emhq_pkg::entry_t     rd_data_a,
    output emhq_pkg::entry_t     rd_data_b
);

    emhq_pkg::entry_t mem [HEAP_DEPTH];

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read two entries; read data is registered and valid in the following cycle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/emhq_ctrl.sv
// Sift controller: accepts one word, walks the heap up or down one level a cycle.
// Depends on emhq_pkg; drives the ports of emhq_store.
`timescale 1ns / 1ps
`default_nettype none

module emhq_ctrl #(
    parameter int HEAP_DEPTH = emhq_pkg::DEPTH_DEFAULT,
    localparam int AW = $clog2(HEAP_DEPTH),
    localparam int CW = $clog2(HEAP_DEPTH + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          operation,
    input  wire logic [emhq_pkg::TIME_W-1:0]   event_time,
    input  wire logic [emhq_pkg::PROC_W-1:0]   process_index,
    input  wire logic [emhq_pkg::KIND_W-1:0]   event_kind,
    output logic                               rd_en,
    output logic [AW-1:0]                      rd_addr_a,
    output logic [AW-1:0]                      rd_addr_b,
    output logic                               wr_en,
    output logic [AW-1:0]                      wr_addr,
    output emhq_pkg::entry_t                   wr_data,
    input  wire emhq_pkg::entry_t              rd_data_a,
    input  wire emhq_pkg::entry_t              rd_data_b,
    output emhq_pkg::result_t                  res,
    input  wire logic                          res_free,
    output logic [CW-1:0]                      count
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LOAD  = 6'b000010,
        S_UP    = 6'b000100,
        S_DOWN  = 6'b001000,
        S_PLACE = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t                state_reg,  state_next;
    logic [CW-1:0]         count_reg,  count_next;
    logic [AW-1:0]         pos_reg,    pos_next;
    emhq_pkg::entry_t      item_reg,   item_next;
    emhq_pkg::entry_t      out_reg,    out_next;
    emhq_pkg::status_t     status_reg, status_next;

    logic                  accept;
    emhq_pkg::entry_t      in_entry;
    logic [CW-1:0]         cnt_dec;
    logic [AW-1:0]         parent;
    logic [AW-1:0]         grand;
    logic [AW+1:0]         n_ext;
    logic [AW+1:0]         l_ext;
    logic [AW+1:0]         r_ext;
    logic                  take_l;
    logic                  take_r;
    emhq_pkg::entry_t      cand;
    logic [AW+1:0]         child_ext;
    emhq_pkg::entry_t      child_entry;
    logic [AW+1:0]         cl_ext;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign count    = count_reg;

    assign in_entry.ev_time = event_time;
    assign in_entry.ev_proc = process_index;
    assign in_entry.ev_kind = event_kind;

    // Heap index arithmetic
    assign cnt_dec = count_reg - CW'(1);
    assign parent  = AW'((pos_reg - AW'(1)) >> 1);
    assign grand   = AW'((parent - AW'(1)) >> 1);
    assign n_ext   = (AW+2)'(count_reg);
    assign l_ext   = {1'b0, pos_reg, 1'b1};
    assign r_ext   = l_ext + (AW+2)'(1);

    // Pick the smaller child; the left child wins a tie, the item stays on a tie
    assign take_l      = emhq_pkg::earlier(rd_data_a, item_reg);
    assign cand        = take_l ? rd_data_a : item_reg;
    assign take_r      = (r_ext < n_ext) && emhq_pkg::earlier(rd_data_b, cand);
    assign child_ext   = take_r ? r_ext : l_ext;
    assign child_entry = take_r ? rd_data_b : rd_data_a;
    assign cl_ext      = {child_ext[AW:0], 1'b1};

    // Result toward the output stage
    assign res.valid  = (state_reg == S_DONE);
    assign res.status = status_reg;
    assign res.entry  = out_reg;

    // Sequence one operation; reads never hit the entry written in the same cycle
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        item_next   = item_reg;
        out_next    = out_reg;
        status_next = status_reg;
        rd_en       = 1'b0;
        rd_addr_a   = '0;
        rd_addr_b   = '0;
        wr_en       = 1'b0;
        wr_addr     = pos_reg;
        wr_data     = item_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_next    = '0;
                    status_next = emhq_pkg::STATUS_OK;
                    if (operation == emhq_pkg::OP_INSERT)
                    begin
                        item_next = in_entry;
                        pos_next  = AW'(count_reg);
                        if (count_reg == CW'(HEAP_DEPTH))
                        begin
                            status_next = emhq_pkg::STATUS_FULL;
                            state_next  = S_DONE;
                        end
                        else if (count_reg == '0)
                        begin
                            count_next = count_reg + CW'(1);
                            state_next = S_PLACE;
                        end
                        else
                        begin
                            count_next = count_reg + CW'(1);
                            rd_en      = 1'b1;
                            rd_addr_a  = AW'(cnt_dec >> 1);
                            state_next = S_UP;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = emhq_pkg::STATUS_EMPTY;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            count_next = cnt_dec;
                            rd_en      = 1'b1;
                            rd_addr_a  = '0;
                            rd_addr_b  = AW'(cnt_dec);
                            state_next = S_LOAD;
                        end
                    end
                end
            end

            S_LOAD:
            begin
                // Take the root as result, move the last entry to a hole at the root
                out_next  = rd_data_a;
                item_next = rd_data_b;
                pos_next  = '0;
                if (count_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else if (count_reg == CW'(1))
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr_a  = AW'(1);
                    rd_addr_b  = AW'(2 % HEAP_DEPTH);
                    state_next = S_DOWN;
                end
            end

            S_UP:
            begin
                wr_en = 1'b1;
                if (emhq_pkg::earlier(item_reg, rd_data_a))
                begin
                    // Move the parent down into the hole
                    wr_data  = rd_data_a;
                    pos_next = parent;
                    if (parent == '0)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        rd_en     = 1'b1;
                        rd_addr_a = grand;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DOWN:
            begin
                wr_en = 1'b1;
                if (take_l || take_r)
                begin
                    // Move the smaller child up into the hole
                    wr_data  = child_entry;
                    pos_next = AW'(child_ext);
                    if (cl_ext < n_ext)
                    begin
                        rd_en     = 1'b1;
                        rd_addr_a = AW'(cl_ext);
                        rd_addr_b = AW'(cl_ext + (AW+2)'(1));
                    end
                    else
                    begin
                        state_next = S_PLACE;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_PLACE:
            begin
                wr_en      = 1'b1;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (res_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Hold working payload
    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        item_reg   <= item_next;
        out_reg    <= out_next;
        status_reg <= status_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(HEAP_DEPTH))
        else $error("entry count above heap depth");

    a_down_has_child: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DOWN) |-> (l_ext < n_ext))
        else $error("sift down without a left child in range");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == emhq_pkg::OP_INSERT && count_reg != CW'(HEAP_DEPTH))
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("accepted insert did not grow the count");

    a_remove_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == emhq_pkg::OP_REMOVE && count_reg != '0)
        |=> (state_reg == S_LOAD && count_reg == $past(count_reg) - CW'(1)))
        else $error("accepted remove did not start a root load");

    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_DONE || state_reg == S_LOAD) |-> !wr_en)
        else $error("heap write outside a sift step");
`endif

endmodule

`default_nettype wire
